>>> hdl/cpt_pkg.sv
// Shared types, codes and constants of the color palette table.
`timescale 1ns / 1ps
package cpt_pkg;

	localparam int MAX_ENTRIES_DEF = 256;
	localparam int CAPACITY_RESET  = 16;
	localparam int DIV_BITS        = 15;
	localparam int CHANNELS        = 3;

	localparam logic [2:0] CMD_ADD  = 3'd0;
	localparam logic [2:0] CMD_SET  = 3'd1;
	localparam logic [2:0] CMD_GET  = 3'd2;
	localparam logic [2:0] CMD_FIND = 3'd3;
	localparam logic [2:0] CMD_GRAD = 3'd4;

	localparam logic [1:0] RSP_HIT  = 2'd0;
	localparam logic [1:0] RSP_MISS = 2'd1;
	localparam logic [1:0] RSP_GET  = 2'd2;

	localparam logic [7:0] LAST_INDEX = 8'hFF;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] end_index;
		logic [7:0] end_red;
		logic [7:0] end_green;
		logic [7:0] end_blue;
	} cpt_req_t;

	typedef struct packed {
		logic [7:0] found_index;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       status;
	} cpt_rsp_t;

	typedef struct packed {
		logic       load;
		logic       ptr_clr;
		logic       ptr_inc;
		logic       rd_en;
		logic       rd_sel_idx;
		logic       wr_set;
		logic       wr_add;
		logic       div_start;
		logic       div_step;
		logic       grad_init;
		logic       grad_step;
		logic       rsp_load;
		logic [1:0] rsp_kind;
	} cpt_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       match;
		logic       srch_end;
		logic       full;
		logic       get_oor;
		logic       rev;
		logic       grad_last;
		logic       div_done;
		logic       out_free;
	} cpt_sts_t;

endpackage

>>> hdl/cpt_ctrl.sv
// Command sequencer of the color palette table.
`timescale 1ns / 1ps
module cpt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  cpt_pkg::cpt_sts_t sts,
	output cpt_pkg::cpt_cmd_t cmd
);
	import cpt_pkg::*;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_DISPATCH = 3'd1;
	localparam logic [2:0] ST_SRCH_CHK = 3'd2;
	localparam logic [2:0] ST_SRCH_CMP = 3'd3;
	localparam logic [2:0] ST_GET_WAIT = 3'd4;
	localparam logic [2:0] ST_DIV      = 3'd5;
	localparam logic [2:0] ST_WALK     = 3'd6;
	localparam logic [2:0] ST_RESP     = 3'd7;

	logic [2:0] state_q, state_d;
	logic [1:0] kind_q, kind_d;

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		cmd     = '0;
		cmd.rsp_kind = kind_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (sts.op)
					CMD_ADD, CMD_FIND: begin
						cmd.ptr_clr = 1'b1;
						state_d     = ST_SRCH_CHK;
					end
					CMD_SET: begin
						cmd.wr_set = 1'b1;
						state_d    = ST_IDLE;
					end
					CMD_GET: begin
						if (sts.get_oor) begin
							kind_d  = RSP_MISS;
							state_d = ST_RESP;
						end else begin
							cmd.rd_en      = 1'b1;
							cmd.rd_sel_idx = 1'b1;
							state_d        = ST_GET_WAIT;
						end
					end
					CMD_GRAD: begin
						if (sts.rev) begin
							state_d = ST_IDLE;
						end else begin
							cmd.div_start = 1'b1;
							cmd.grad_init = 1'b1;
							state_d       = ST_DIV;
						end
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_SRCH_CHK: begin
				if (sts.srch_end) begin
					if (sts.op == CMD_ADD && !sts.full) begin
						cmd.wr_add = 1'b1;
						kind_d     = RSP_HIT;
					end else begin
						kind_d = RSP_MISS;
					end
					state_d = ST_RESP;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = ST_SRCH_CMP;
				end
			end
			ST_SRCH_CMP: begin
				if (sts.match) begin
					kind_d  = RSP_HIT;
					state_d = ST_RESP;
				end else begin
					cmd.ptr_inc = 1'b1;
					state_d     = ST_SRCH_CHK;
				end
			end
			ST_GET_WAIT: begin
				kind_d  = RSP_GET;
				state_d = ST_RESP;
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_d = ST_WALK;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_WALK: begin
				cmd.grad_step = 1'b1;
				if (sts.grad_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_RESP: begin
				if (sts.out_free) begin
					cmd.rsp_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign req_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= RSP_MISS;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	// An accepted request always goes to command decode next.
	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == ST_DISPATCH))
		else $error("accepted request did not reach decode");

	// A result is only loaded when the output register can take it.
	a_rsp_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rsp_load |-> sts.out_free)
		else $error("result loaded over a pending one");

	// The gradient walk only starts after the divider finished.
	a_walk_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && $past(state_q) == ST_DIV) |-> $past(sts.div_done))
		else $error("gradient walk started early");

endmodule

>>> hdl/cpt_dp.sv
// Datapath of the color palette table: palette memory, search, divider, output.
`timescale 1ns / 1ps
module cpt_dp #(
	parameter int MAX_ENTRIES = cpt_pkg::MAX_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cpt_pkg::cpt_req_t req,
	input  logic              cfg_valid,
	input  logic [7:0]        cfg_data,
	input  cpt_pkg::cpt_cmd_t cmd,
	output cpt_pkg::cpt_sts_t sts,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output cpt_pkg::cpt_rsp_t rsp
);
	import cpt_pkg::*;

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	cpt_req_t    req_q;
	logic [7:0]  cap_q;
	logic [7:0]  fill_q;
	logic [7:0]  ptr_q;
	logic [8:0]  size;

	logic [23:0] mem [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] vld_q;
	logic [23:0] rd_data_s1;
	logic        rd_vld_s1;
	logic [23:0] rd_color;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [23:0] wr_data;
	logic        wr_en;

	logic [7:0]  s_ch [CHANNELS];
	logic [7:0]  e_ch [CHANNELS];
	logic [7:0]  span;
	logic [7:0]  div_n;
	logic        neg_q   [CHANNELS];
	logic [7:0]  rem_q   [CHANNELS];
	logic [DIV_BITS-1:0] quo_q [CHANNELS];
	logic [3:0]  div_cnt_q;
	logic [15:0] acc_q   [CHANNELS];
	logic [15:0] step    [CHANNELS];

	logic        rsp_valid_q;
	cpt_rsp_t    rsp_q;

	assign size = (9'(cap_q) < 9'(MAX_ENTRIES)) ? 9'(cap_q) : 9'(MAX_ENTRIES);

	assign s_ch[0] = req_q.red;
	assign s_ch[1] = req_q.green;
	assign s_ch[2] = req_q.blue;
	assign e_ch[0] = req_q.end_red;
	assign e_ch[1] = req_q.end_green;
	assign e_ch[2] = req_q.end_blue;
	assign span    = req_q.end_index - req_q.index;
	assign div_n   = (span == 8'd0) ? 8'd1 : span;

	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			step[c] = neg_q[c] ? (16'd0 - {quo_q[c], 1'b0}) : {quo_q[c], 1'b0};
		end
	end

	// Request and configuration registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= 8'(CAPACITY_RESET);
			fill_q <= '0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (cmd.wr_add) begin
				fill_q <= fill_q + 8'd1;
			end
		end
	end

	// Pointer for search and gradient walk.
	always_ff @(posedge clk) begin
		if (cmd.ptr_clr) begin
			ptr_q <= '0;
		end else if (cmd.wr_add) begin
			ptr_q <= fill_q;
		end else if (cmd.grad_init) begin
			ptr_q <= req_q.index;
		end else if (cmd.ptr_inc || cmd.grad_step) begin
			ptr_q <= ptr_q + 8'd1;
		end
	end

	// Palette memory; an entry never written since reset reads as black.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ptr_q[AW-1:0];
		wr_data = {req_q.red, req_q.green, req_q.blue};
		if (cmd.wr_set) begin
			wr_en   = (9'(req_q.index) < size);
			wr_addr = req_q.index[AW-1:0];
		end else if (cmd.wr_add) begin
			wr_en   = 1'b1;
			wr_addr = fill_q[AW-1:0];
		end else if (cmd.grad_step) begin
			wr_en   = (9'(ptr_q) < size);
			wr_data = {acc_q[0][15:8], acc_q[1][15:8], acc_q[2][15:8]};
		end
	end

	assign rd_addr = cmd.rd_sel_idx ? req_q.index[AW-1:0] : ptr_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			rd_vld_s1  <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_color = rd_vld_s1 ? rd_data_s1 : 24'd0;

	// Restoring divider, one quotient bit per cycle for all channels.
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_cnt_q <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				neg_q[c] <= (e_ch[c] < s_ch[c]);
				rem_q[c] <= '0;
				quo_q[c] <= (e_ch[c] < s_ch[c]) ? {s_ch[c] - e_ch[c], 7'd0}
				                                : {e_ch[c] - s_ch[c], 7'd0};
			end
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 4'd1;
			for (int c = 0; c < CHANNELS; c++) begin
				if ({rem_q[c], quo_q[c][DIV_BITS-1]} >= {1'b0, div_n}) begin
					rem_q[c] <= 8'({rem_q[c], quo_q[c][DIV_BITS-1]} - {1'b0, div_n});
					quo_q[c] <= {quo_q[c][DIV_BITS-2:0], 1'b1};
				end else begin
					rem_q[c] <= {rem_q[c][6:0], quo_q[c][DIV_BITS-1]};
					quo_q[c] <= {quo_q[c][DIV_BITS-2:0], 1'b0};
				end
			end
		end
	end

	// 8.8 accumulators; only the upper byte is stored, so wrap is harmless.
	always_ff @(posedge clk) begin
		for (int c = 0; c < CHANNELS; c++) begin
			if (cmd.grad_init) begin
				acc_q[c] <= {s_ch[c], 8'd0};
			end else if (cmd.grad_step) begin
				acc_q[c] <= acc_q[c] + step[c];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rsp_load) begin
			rsp_q <= '0;
			case (cmd.rsp_kind)
				RSP_HIT:  rsp_q.found_index <= ptr_q;
				RSP_GET:  {rsp_q.out_red, rsp_q.out_green, rsp_q.out_blue} <= rd_color;
				default:  rsp_q.status <= 1'b1;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign sts.op        = req_q.cmd;
	assign sts.match     = (rd_color == {req_q.red, req_q.green, req_q.blue});
	assign sts.srch_end  = (ptr_q >= fill_q);
	assign sts.full      = (9'(fill_q) >= size);
	assign sts.get_oor   = (req_q.index == LAST_INDEX) || (9'(req_q.index) >= size);
	assign sts.rev       = (req_q.end_index < req_q.index);
	assign sts.grad_last = (ptr_q == req_q.end_index);
	assign sts.div_done  = (div_cnt_q == 4'(DIV_BITS));
	assign sts.out_free  = !rsp_valid_q || !rsp_stall;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		9'(fill_q) <= 9'(MAX_ENTRIES))
		else $error("fill count beyond table");

	a_add_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_add |-> !sts.full)
		else $error("append into a full table");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (div_cnt_q < 4'(DIV_BITS)))
		else $error("divider stepped past its width");

endmodule

>>> hdl/color_palette_table.sv
// Top level of the color palette table: sequencer plus datapath.
//
// Usage: requests enter on req/req_valid and are taken when req_stall is
// low. Commands are add, set, get, find and gradient fill. Add, get and
// find each return one result on rsp/rsp_valid; the receiver holds it by
// raising rsp_stall, and the result stays unchanged until taken. Set,
// gradient and unused commands return nothing.
// The capacity register is written on cfg_data/cfg_valid; cfg_ready is
// always high. Write it only while the block is idle.
// Sequence: one request is worked on at a time. Set is decoded and
// written; get is decoded, read and answered, and an out-of-range get
// skips the read. A find or add visits the filled palette entries in
// order (one memory read and one compare each) until a hit or the fill
// count. A gradient is decoded and runs the 15-bit divider on all
// channels, then writes its span in order; a reversed span ends at decode.
// A new request is taken while a finished result is still waiting; only
// a second result must wait for the first to leave the output register.
// Reset clears the fill count, sets capacity to 16 and marks every entry
// as never written, so all entries read black at once with no clearing
// pass.
`timescale 1ns / 1ps
module color_palette_table #(
	parameter int MAX_ENTRIES = cpt_pkg::MAX_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  cpt_pkg::cpt_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output cpt_pkg::cpt_rsp_t rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        cfg_data
);
	import cpt_pkg::*;

	cpt_cmd_t cmd;
	cpt_sts_t sts;

	// Configuration is always accepted; the register lives in the datapath.
	assign cfg_ready = 1'b1;

	// The sequencer decodes each request and walks its steps.
	cpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the palette, the search pointer, the divider,
	// the gradient accumulators and the output register.
	cpt_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

>>> bench/tb_color_palette_table.sv
// Self-checking testbench of the color palette table.
`timescale 1ns / 1ps
module tb_color_palette_table;
	import cpt_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 1200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	cpt_req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	cpt_rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_data = 8'd0;

	always #4 clk = ~clk;

	color_palette_table u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Shadow copy of the palette, kept up to date as each request is accepted.
	logic [23:0] shadow_palette [256];
	int unsigned shadow_fill;
	int unsigned shadow_capacity;

	cpt_req_t pending_reqs[$];
	cpt_rsp_t expected_rsps[$];
	int error_count = 0;
	int idle_cycles = 0;
	bit calm_stretch = 1'b0; // stretch with no idling on either side
	bit timed_out = 1'b0;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic logic [15:0] channel_step(input int s, input int e, input int n);
		int mag;
		if (e >= s) begin
			mag = ((e - s) << 7) / n;
			return 16'((mag * 2));
		end
		mag = ((s - e) << 7) / n;
		return 16'(-(mag * 2));
	endfunction

	// Works out the palette effect of one request; returns 1 when a result is due.
	function automatic bit palette_apply(input cpt_req_t r, output cpt_rsp_t res);
		logic [23:0] color;
		int unsigned size;
		int hit;
		logic [15:0] step [3];
		logic [15:0] acc [3];
		int n;
		color = {r.red, r.green, r.blue};
		size = shadow_capacity;
		res = '0;
		hit = -1;
		for (int i = 0; i < shadow_fill; i++)
			if (hit < 0 && shadow_palette[i] == color)
				hit = i;
		case (r.cmd)
			CMD_ADD: begin
				if (hit >= 0)
					res.found_index = 8'(hit);
				else if (shadow_fill >= size)
					res.status = 1'b1;
				else begin
					shadow_palette[shadow_fill] = color;
					res.found_index = 8'(shadow_fill);
					shadow_fill++;
				end
				return 1'b1;
			end
			CMD_SET: begin
				if (r.index < size)
					shadow_palette[r.index] = color;
				return 1'b0;
			end
			CMD_GET: begin
				if (r.index == LAST_INDEX || r.index >= size)
					res.status = 1'b1;
				else
					{res.out_red, res.out_green, res.out_blue} = shadow_palette[r.index];
				return 1'b1;
			end
			CMD_FIND: begin
				if (hit >= 0)
					res.found_index = 8'(hit);
				else
					res.status = 1'b1;
				return 1'b1;
			end
			CMD_GRAD: begin
				if (r.end_index < r.index)
					return 1'b0;
				n = r.end_index - r.index;
				if (n == 0)
					n = 1;
				step[0] = channel_step(r.red, r.end_red, n);
				step[1] = channel_step(r.green, r.end_green, n);
				step[2] = channel_step(r.blue, r.end_blue, n);
				acc[0] = {r.red, 8'd0};
				acc[1] = {r.green, 8'd0};
				acc[2] = {r.blue, 8'd0};
				for (int k = r.index; k <= r.end_index; k++) begin
					if (k < size)
						shadow_palette[k] = {acc[0][15:8], acc[1][15:8], acc[2][15:8]};
					for (int c = 0; c < 3; c++)
						acc[c] += step[c];
				end
				return 1'b0;
			end
			default: return 1'b0;
		endcase
	endfunction

	// Driver: holds a request until accepted, then moves to the next or idles.
	always @(posedge clk) begin
		cpt_rsp_t res;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				if (palette_apply(req, res))
					expected_rsps.push_back(res);
				void'(pending_reqs.pop_front());
			end
			if (!(req_valid && req_stall)) begin
				if (pending_reqs.size() > 0 && (calm_stretch || $urandom_range(99) >= 34)) begin
					req_valid <= 1'b1;
					req <= pending_reqs[0];
				end else
					req_valid <= 1'b0;
			end
			rsp_stall <= !calm_stretch && $urandom_range(99) < 34;
		end
	end

	// Monitor: compares each accepted result with the oldest expectation.
	always @(posedge clk) begin
		cpt_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsps.size() == 0)
				report_mismatch("result with none expected", 0, 0);
			else begin
				want = expected_rsps.pop_front();
				if (rsp.found_index !== want.found_index)
					report_mismatch("found_index", rsp.found_index, want.found_index);
				if (rsp.out_red !== want.out_red)
					report_mismatch("out_red", rsp.out_red, want.out_red);
				if (rsp.out_green !== want.out_green)
					report_mismatch("out_green", rsp.out_green, want.out_green);
				if (rsp.out_blue !== want.out_blue)
					report_mismatch("out_blue", rsp.out_blue, want.out_blue);
				if (rsp.status !== want.status)
					report_mismatch("status", rsp.status, want.status);
			end
		end
	end

	// Watchdog: cycles with nothing accepted on any channel.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_valid)
			idle_cycles <= 0;
		else if (pending_reqs.size() > 0 || expected_rsps.size() > 0)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("** color_palette_table: FAILED **");
			$finish;
		end
	end

	function automatic cpt_req_t make_req(input logic [2:0] cmd, input int idx,
	                                       input logic [23:0] c, input int eidx,
	                                       input logic [23:0] ec);
		cpt_req_t r;
		r.cmd = cmd;
		r.index = 8'(idx);
		{r.red, r.green, r.blue} = c;
		r.end_index = 8'(eidx);
		{r.end_red, r.end_green, r.end_blue} = ec;
		return r;
	endfunction

	// Colors come from a small pool so that adds and finds often hit.
	function automatic logic [23:0] pick_color();
		logic [23:0] pool [6] = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
		                          24'h0000FF, 24'h123456};
		if ($urandom_range(99) < 60)
			return pool[$urandom_range(5)];
		return 24'($urandom);
	endfunction

	function automatic cpt_req_t random_req(input int unsigned cap);
		cpt_req_t r;
		int span;
		int lim;
		int sel;
		r = cpt_req_t'({$urandom, $urandom, $urandom});
		lim = (cap > 0) ? cap + 2 : 4;
		sel = $urandom_range(99);
		if (sel < 30)
			r.cmd = CMD_ADD;
		else if (sel < 45)
			r.cmd = CMD_SET;
		else if (sel < 65)
			r.cmd = CMD_GET;
		else if (sel < 82)
			r.cmd = CMD_FIND;
		else if (sel < 95)
			r.cmd = CMD_GRAD;
		if (r.cmd != CMD_GRAD && r.cmd <= CMD_FIND) begin
			{r.red, r.green, r.blue} = pick_color();
			if ($urandom_range(9) != 0)
				r.index = 8'($urandom_range(lim - 1));
		end
		// Mostly short gradient spans; a few are reversed or run off the table.
		if (r.cmd == CMD_GRAD && $urandom_range(9) != 0) begin
			r.index = 8'($urandom_range(lim - 1));
			span = $urandom_range(12);
			r.end_index = (r.index + span > 255) ? 8'd255 : 8'(r.index + span);
		end
		return r;
	endfunction

	// Waits until the block has drained all expected results and settled.
	task automatic wait_idle();
		while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input int unsigned value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= 8'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_capacity = value;
	endtask

	initial begin
		int unsigned caps [6] = '{16, 255, 0, 1, 40, 200};
		for (int i = 0; i < 256; i++)
			shadow_palette[i] = 24'd0;
		shadow_fill = 0;
		shadow_capacity = CAPACITY_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset capacity.
		pending_reqs.push_back(make_req(CMD_GET, 0, 24'h0, 0, 24'h0));
		pending_reqs.push_back(make_req(CMD_FIND, 0, 24'h0, 0, 24'h0));
		pending_reqs.push_back(make_req(CMD_ADD, 0, 24'hFFFFFF, 0, 24'h0));
		pending_reqs.push_back(make_req(CMD_ADD, 0, 24'h000000, 0, 24'h0));
		pending_reqs.push_back(make_req(CMD_ADD, 0, 24'hFFFFFF, 0, 24'h0));
		pending_reqs.push_back(make_req(CMD_FIND, 0, 24'h000000, 0, 24'h0));
		pending_reqs.push_back(make_req(CMD_SET, 15, 24'hABCDEF, 0, 24'h0));
		pending_reqs.push_back(make_req(CMD_SET, 16, 24'h111111, 0, 24'h0));
		pending_reqs.push_back(make_req(CMD_GET, 15, 24'h0, 0, 24'h0));
		pending_reqs.push_back(make_req(CMD_GET, 16, 24'h0, 0, 24'h0));
		pending_reqs.push_back(make_req(CMD_GET, 255, 24'h0, 0, 24'h0));
		pending_reqs.push_back(make_req(CMD_GRAD, 2, 24'h00FF10, 9, 24'hFF00F0));
		pending_reqs.push_back(make_req(CMD_GRAD, 5, 24'h123456, 5, 24'h654321));
		pending_reqs.push_back(make_req(CMD_GRAD, 9, 24'hFFFFFF, 3, 24'h000000));
		pending_reqs.push_back(make_req(CMD_GRAD, 10, 24'hFF0000, 255, 24'h00FFFF));
		pending_reqs.push_back(make_req(3'd5, 0, 24'h0, 0, 24'h0));
		pending_reqs.push_back(make_req(3'd7, 255, 24'hFFFFFF, 255, 24'hFFFFFF));
		pending_reqs.push_back(make_req(CMD_GET, 3, 24'h0, 0, 24'h0));
		for (int i = 0; i < 16; i++)
			pending_reqs.push_back(make_req(CMD_ADD, 0, 24'(i * 24'h010203 + 1), 0, 24'h0));
		wait_idle();

		// Random phases over several capacities, each starting idle.
		for (int p = 0; p < 6; p++) begin
			write_capacity(caps[p]);
			calm_stretch = (p == 1);
			for (int i = 0; i < 310; i++)
				pending_reqs.push_back(random_req(caps[p]));
			wait_idle();
		end

		if (error_count == 0)
			$display("** color_palette_table: PASSED **");
		else
			$display("** color_palette_table: FAILED **");
		$finish;
	end
endmodule

>>> sim.f
hdl/cpt_pkg.sv
hdl/cpt_ctrl.sv
hdl/cpt_dp.sv
hdl/color_palette_table.sv
bench/tb_color_palette_table.sv
